/* rtl/brf_pkg.sv */
// Shared types and constants for the broadcast ring FIFO.
// Used by brf_slots, brf_readers, broadcast_ring_fifo_unit and brf_checker.
`timescale 1ns / 1ps
`default_nettype none

package brf_pkg;

  // Default sizes of the ring.
  localparam int DEFAULT_DEPTH       = 8;
  localparam int DEFAULT_NUM_READERS = 4;
  localparam int DEFAULT_WORD_BITS   = 32;

  // Fixed port field widths.
  localparam int OPCODE_W    = 1;
  localparam int READER_ID_W = 2;
  localparam int WORD_W      = 32;

  typedef enum logic [OPCODE_W-1:0] {
    OP_WRITE = 1'b0,
    OP_READ  = 1'b1
  } opcode_t;

  // Commands from the access stage to the slot bank.
  typedef struct packed {
    logic write_en;  // store a word at the write pointer
    logic take_en;   // mark the slot at the read pointer as taken by one more reader
  } slot_ctl_t;

endpackage : brf_pkg

`default_nettype wire

/* rtl/broadcast_ring_fifo_unit.sv */
// Broadcast ring FIFO top level: request register, access stage and result register.
// Depends on brf_pkg, brf_slots and brf_readers.
//
// Usage:
//   A request is taken on a rising edge with start high and busy low. opcode selects
//   a write of write_word or a read by reader reader_id. Every reader sees every
//   stored word once, in write order; a write is refused while the slot under the
//   write pointer still waits for some reader.
//   Each request gives exactly one result: strobe is high for one cycle with
//   done_res and read_word. done_res is 1 for a stored write or a returned word;
//   read_word carries the word on a successful read and is zero otherwise.
//   A request passes the request register, the access stage and the result register.
//   Throughput: one request per cycle while busy is low; slot and reader state is read
//   and updated in the single access stage, so back-to-back requests see each other.
//   busy is high in reset and in the cycle following it; after that every cycle accepts.
//   Reset (rst, synchronous) empties the ring, clears all reader pointers and
//   pending counts and drops any request in flight. The receiver cannot stall:
//   results are shown for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none

module broadcast_ring_fifo_unit
  import brf_pkg::*;
#(
  parameter int DEPTH       = DEFAULT_DEPTH,
  parameter int NUM_READERS = DEFAULT_NUM_READERS,
  parameter int WORD_BITS   = DEFAULT_WORD_BITS
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  output logic                        busy,
  input  wire logic [OPCODE_W-1:0]    opcode,
  input  wire logic [READER_ID_W-1:0] reader_id,
  input  wire logic [WORD_W-1:0]      write_word,
  output logic                        strobe,
  output logic                        done_res,
  output logic [WORD_W-1:0]           read_word
);

  localparam int PTR_W     = $clog2(DEPTH);
  localparam int SLOT_BITS = (WORD_BITS < WORD_W) ? WORD_BITS : WORD_W;

  logic                   in_valid;
  opcode_t                in_op;
  logic [READER_ID_W-1:0] in_rid;
  logic [SLOT_BITS-1:0]   in_word;
  logic [PTR_W-1:0]       write_pointer;
  logic [PTR_W-1:0]       write_pointer_next;

  logic                   accept;
  logic                   rd_req;
  logic                   wr_free;
  logic                   wr_commit;
  logic                   grant;
  logic [PTR_W-1:0]       rd_ptr;
  logic [SLOT_BITS-1:0]   rd_data;
  slot_ctl_t              ctl;

  assign accept = start && !busy;

  // Request register.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      in_valid <= 1'b0;
    end else begin
      busy     <= 1'b0;
      in_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_op   <= opcode_t'(opcode);
      in_rid  <= reader_id;
      in_word <= write_word[SLOT_BITS-1:0];
    end
  end

  // Access stage.
  assign rd_req       = in_valid && in_op == OP_READ;
  assign wr_commit    = in_valid && in_op == OP_WRITE && wr_free;
  assign ctl.write_en = wr_commit;
  assign ctl.take_en  = grant;

  assign write_pointer_next = (write_pointer == PTR_W'(DEPTH - 1)) ? '0 :
                              write_pointer + 1'b1;

  brf_slots #(
    .DEPTH      (DEPTH),
    .NUM_READERS(NUM_READERS),
    .SLOT_BITS  (SLOT_BITS)
  ) u_slots (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .wr_addr(write_pointer),
    .wr_data(in_word),
    .rd_addr(rd_ptr),
    .wr_free(wr_free),
    .rd_data(rd_data)
  );

  brf_readers #(
    .DEPTH      (DEPTH),
    .NUM_READERS(NUM_READERS)
  ) u_readers (
    .clk      (clk),
    .rst      (rst),
    .rd_req   (rd_req),
    .reader_id(in_rid),
    .wr_commit(wr_commit),
    .grant    (grant),
    .rd_ptr   (rd_ptr)
  );

  // Write pointer and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      write_pointer <= '0;
      strobe        <= 1'b0;
      done_res      <= 1'b0;
      read_word     <= '0;
    end else begin
      if (wr_commit) begin
        write_pointer <= write_pointer_next;
      end
      strobe    <= in_valid;
      done_res  <= wr_commit || grant;
      read_word <= grant ? WORD_W'(rd_data) : '0;
    end
  end

endmodule : broadcast_ring_fifo_unit

`default_nettype wire

/* rtl/brf_slots.sv */
// Slot bank of the broadcast ring FIFO: stored words, written flags and per-slot
// taken counts. Depends on brf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module brf_slots
  import brf_pkg::*;
#(
  parameter int DEPTH       = DEFAULT_DEPTH,
  parameter int NUM_READERS = DEFAULT_NUM_READERS,
  parameter int SLOT_BITS   = DEFAULT_WORD_BITS
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire slot_ctl_t                ctl,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [SLOT_BITS-1:0]     wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic                          wr_free,
  output logic [SLOT_BITS-1:0]          rd_data
);

  localparam int PTR_W   = $clog2(DEPTH);
  localparam int TAKEN_W = $clog2(NUM_READERS + 1);

  logic [SLOT_BITS-1:0] slot_store [DEPTH];
  logic [TAKEN_W-1:0]   slot_taken_count [DEPTH];
  logic [DEPTH-1:0]     slot_written;
  logic [DEPTH-1:0]     slot_free;

  for (genvar i = 0; i < DEPTH; i++) begin : g_slot
    always_ff @(posedge clk) begin
      if (rst) begin
        slot_written[i]     <= 1'b0;
        slot_taken_count[i] <= '0;
      end else if (ctl.write_en && wr_addr == PTR_W'(i)) begin
        slot_written[i]     <= 1'b1;
        slot_taken_count[i] <= '0;
      end else if (ctl.take_en && rd_addr == PTR_W'(i) &&
                   slot_taken_count[i] < TAKEN_W'(NUM_READERS)) begin
        slot_taken_count[i] <= slot_taken_count[i] + 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (ctl.write_en && wr_addr == PTR_W'(i)) begin
        slot_store[i] <= wr_data;
      end
    end

    // A slot may be overwritten once every reader has taken it.
    assign slot_free[i] = !slot_written[i] ||
                          slot_taken_count[i] >= TAKEN_W'(NUM_READERS);
  end

  assign wr_free = slot_free[wr_addr];
  assign rd_data = slot_store[rd_addr];

endmodule : brf_slots

`default_nettype wire

/* rtl/brf_readers.sv */
// Per-reader state of the broadcast ring FIFO: read pointers and pending counts.
// Depends on brf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module brf_readers
  import brf_pkg::*;
#(
  parameter int DEPTH       = DEFAULT_DEPTH,
  parameter int NUM_READERS = DEFAULT_NUM_READERS
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     rd_req,
  input  wire logic [READER_ID_W-1:0]   reader_id,
  input  wire logic                     wr_commit,
  output logic                          grant,
  output logic [$clog2(DEPTH)-1:0]      rd_ptr
);

  localparam int PTR_W  = $clog2(DEPTH);
  localparam int PEND_W = $clog2(DEPTH + 1);

  logic [PTR_W-1:0]       reader_pointer [NUM_READERS];
  logic [PEND_W-1:0]      reader_pending [NUM_READERS];
  logic [NUM_READERS-1:0] rd_sel;
  logic [NUM_READERS-1:0] has_word;

  for (genvar r = 0; r < NUM_READERS; r++) begin : g_reader
    // Readers beyond the id range can never be addressed.
    if (r < (1 << READER_ID_W)) begin : g_addr
      assign rd_sel[r] = (reader_id == READER_ID_W'(r));
    end else begin : g_noaddr
      assign rd_sel[r] = 1'b0;
    end

    assign has_word[r] = (reader_pending[r] != '0);

    always_ff @(posedge clk) begin
      if (rst) begin
        reader_pointer[r] <= '0;
        reader_pending[r] <= '0;
      end else if (grant && rd_sel[r]) begin
        reader_pointer[r] <= (reader_pointer[r] == PTR_W'(DEPTH - 1)) ? '0 :
                             reader_pointer[r] + 1'b1;
        reader_pending[r] <= reader_pending[r] - 1'b1;
      end else if (wr_commit && reader_pending[r] < PEND_W'(DEPTH)) begin
        reader_pending[r] <= reader_pending[r] + 1'b1;
      end
    end
  end

  assign grant = rd_req && |(rd_sel & has_word);

  always_comb begin
    rd_ptr = '0;
    for (int r = 0; r < NUM_READERS; r++) begin
      if (rd_sel[r]) begin
        rd_ptr = rd_ptr | reader_pointer[r];
      end
    end
  end

endmodule : brf_readers

`default_nettype wire

/* rtl/brf_checker.sv */
// Port-level checks for broadcast_ring_fifo_unit, attached by bind.
// Depends on brf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module brf_checker
  import brf_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   start,
  input wire logic                   busy,
  input wire logic [OPCODE_W-1:0]    opcode,
  input wire logic                   strobe,
  input wire logic                   done_res,
  input wire logic [WORD_W-1:0]      read_word
);

  // Every accepted request gives a result through the request and result registers.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##2 strobe)
    else $error("accepted request produced no result");

  // No result without an earlier accepted request.
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(start && !busy, 2))
    else $error("result without a request");

  // A refused or empty request carries no word.
  a_zero_word: assert property (@(posedge clk) disable iff (rst)
    (strobe && !done_res) |-> read_word == '0)
    else $error("word on a result that is not done");

  // Writes never return a word.
  a_write_no_word: assert property (@(posedge clk) disable iff (rst)
    (strobe && $past(opcode, 2) == OP_WRITE) |-> read_word == '0)
    else $error("word returned on a write");

  // Busy only in the cycle after reset.
  a_busy_after_reset: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> !busy)
    else $error("busy outside reset recovery");

endmodule : brf_checker

bind broadcast_ring_fifo_unit brf_checker u_brf_checker (
  .clk      (clk),
  .rst      (rst),
  .start    (start),
  .busy     (busy),
  .opcode   (opcode),
  .strobe   (strobe),
  .done_res (done_res),
  .read_word(read_word)
);

`default_nettype wire

/* verif/broadcast_ring_fifo_unit_tb.sv */
// Self-checking testbench for broadcast_ring_fifo_unit: a directed table, then random requests.
// Results are checked with quoted outcomes or a shadow ring. Depends on brf_pkg and the RTL.
`timescale 1ns / 1ps

module broadcast_ring_fifo_unit_tb;
  import brf_pkg::*;

  localparam int RING_DEPTH   = DEFAULT_DEPTH;
  localparam int READERS      = DEFAULT_NUM_READERS;
  localparam int RANDOM_COUNT = 750;
  localparam int CALM_TAIL    = 120;
  localparam int CYCLE_LIMIT  = 100000;
  localparam int DRAIN_CYCLES = 8;
  localparam int REPORT_MAX   = 10;

  typedef struct packed {
    logic              done;
    logic [WORD_W-1:0] word;
  } outcome_t;

  typedef struct {
    opcode_t                op;
    logic [READER_ID_W-1:0] rid;
    logic [WORD_W-1:0]      wdata;
    bit                     quoted;
    outcome_t               outcome;
  } request_row_t;

  typedef struct {
    bit       quoted;
    outcome_t outcome;
  } quote_t;

  logic                   clk;
  logic                   rst;
  logic                   start;
  logic                   busy;
  logic [OPCODE_W-1:0]    opcode;
  logic [READER_ID_W-1:0] reader_id;
  logic [WORD_W-1:0]      write_word;
  logic                   strobe;
  logic                   done_res;
  logic [WORD_W-1:0]      read_word;

  // Shadow copy of the ring
  logic [WORD_W-1:0] ring_word [RING_DEPTH];
  int unsigned       taken_cnt [RING_DEPTH];
  bit                slot_filled [RING_DEPTH];
  int unsigned       wr_ptr;
  int unsigned       rd_ptr [READERS];
  int unsigned       unread [READERS];

  outcome_t     awaited_results[$];
  quote_t       quoted_results[$];
  request_row_t stim_rows[$];
  int unsigned  mismatches;
  int unsigned  cycle_count;

  broadcast_ring_fifo_unit i_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .opcode     (opcode),
    .reader_id  (reader_id),
    .write_word (write_word),
    .strobe     (strobe),
    .done_res   (done_res),
    .read_word  (read_word)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Apply one request to the shadow ring and return what the block should answer.
  function automatic outcome_t ring_access(opcode_t op, logic [READER_ID_W-1:0] rid,
                                           logic [WORD_W-1:0] wdata);
    outcome_t    res;
    int unsigned r;
    int unsigned p;
    res = '0;
    if (op == OP_WRITE) begin
      if (!slot_filled[wr_ptr] || taken_cnt[wr_ptr] >= READERS) begin
        ring_word[wr_ptr]   = wdata;
        taken_cnt[wr_ptr]   = 0;
        slot_filled[wr_ptr] = 1'b1;
        wr_ptr = (wr_ptr + 1 >= RING_DEPTH) ? 0 : wr_ptr + 1;
        for (int i = 0; i < READERS; i++) begin
          if (unread[i] < RING_DEPTH) unread[i]++;
        end
        res.done = 1'b1;
      end
    end else if (int'(rid) < READERS) begin
      r = rid;
      if (unread[r] != 0) begin
        p = rd_ptr[r];
        res.word = slot_filled[p] ? ring_word[p] : '0;
        if (taken_cnt[p] < READERS) taken_cnt[p]++;
        rd_ptr[r] = (p + 1 >= RING_DEPTH) ? 0 : p + 1;
        unread[r]--;
        res.done = 1'b1;
      end
    end
    return res;
  endfunction

  task automatic add_row(opcode_t op, logic [READER_ID_W-1:0] rid, logic [WORD_W-1:0] wdata,
                         bit quoted = 1'b0, logic done = 1'b0, logic [WORD_W-1:0] word = '0);
    request_row_t row;
    row.op      = op;
    row.rid     = rid;
    row.wdata   = wdata;
    row.quoted  = quoted;
    row.outcome = '{done: done, word: word};
    stim_rows.push_back(row);
  endtask

  // Present one request from the falling edge and hold it until the block takes it.
  task automatic issue(opcode_t op, logic [READER_ID_W-1:0] rid, logic [WORD_W-1:0] wdata,
                       bit quoted, outcome_t outcome, bit allow_gap);
    quote_t q;
    if (allow_gap && $urandom_range(0, 3) == 0) begin
      start = 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    q.quoted  = quoted;
    q.outcome = outcome;
    quoted_results.push_back(q);
    start      = 1'b1;
    opcode     = op;
    reader_id  = rid;
    write_word = wdata;
    while (busy) @(negedge clk);
    @(negedge clk);
  endtask

  // Sample at the rising edge: check the result, then record any request taken.
  always @(posedge clk) begin
    outcome_t got;
    outcome_t want;
    outcome_t predicted;
    quote_t   q;
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, awaited_results.size());
      $display("== FAIL ==");
      $finish;
    end
    if (!rst) begin
      if (strobe) begin
        got = '{done: done_res, word: read_word};
        if (awaited_results.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("unexpected result: done_res=%0b read_word=%h", done_res, read_word);
        end else begin
          want = awaited_results.pop_front();
          if (got.done !== want.done || got.word !== want.word) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
              $display("mismatch at cycle %0d: done_res exp %0b got %0b, read_word exp %h got %h",
                       cycle_count, want.done, got.done, want.word, got.word);
          end
        end
      end
      if (start && !busy) begin
        predicted = ring_access(opcode_t'(opcode), reader_id, write_word);
        q = quoted_results.pop_front();
        awaited_results.push_back(q.quoted ? q.outcome : predicted);
      end
    end
  end

  initial begin
    int unsigned write_pct;
    outcome_t    none;
    logic [WORD_W-1:0] wdata;
    opcode_t     op;
    none        = '0;
    mismatches  = 0;
    cycle_count = 0;
    wr_ptr      = 0;
    for (int i = 0; i < RING_DEPTH; i++) begin
      ring_word[i]   = '0;
      taken_cnt[i]   = 0;
      slot_filled[i] = 1'b0;
    end
    for (int i = 0; i < READERS; i++) begin
      rd_ptr[i] = 0;
      unread[i] = 0;
    end
    rst        = 1'b1;
    start      = 1'b0;
    opcode     = OP_WRITE;
    reader_id  = '0;
    write_word = '0;

    // Empty ring, extreme words, ring full, all readers freeing the oldest slot
    add_row(OP_READ,  2'd0, 32'hFFFF_FFFF, 1'b1, 1'b0, '0);
    add_row(OP_READ,  2'd3, 32'h0000_0000, 1'b1, 1'b0, '0);
    add_row(OP_WRITE, 2'd3, 32'hFFFF_FFFF, 1'b1, 1'b1, '0);
    add_row(OP_WRITE, 2'd0, 32'h0000_0000, 1'b1, 1'b1, '0);
    add_row(OP_READ,  2'd0, 32'h0000_0000, 1'b1, 1'b1, 32'hFFFF_FFFF);
    add_row(OP_READ,  2'd0, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'h0000_0000);
    add_row(OP_READ,  2'd0, 32'h1234_5678, 1'b1, 1'b0, '0);
    add_row(OP_WRITE, 2'd1, 32'hA5A5_A5A5);
    add_row(OP_WRITE, 2'd2, 32'h5A5A_5A5A);
    add_row(OP_WRITE, 2'd0, 32'h0000_0001);
    add_row(OP_WRITE, 2'd3, 32'h8000_0000);
    add_row(OP_WRITE, 2'd0, 32'h7FFF_FFFF);
    add_row(OP_WRITE, 2'd2, 32'hDEAD_BEEF);
    add_row(OP_WRITE, 2'd1, 32'hCAFE_F00D, 1'b1, 1'b0, '0);
    add_row(OP_READ,  2'd1, 32'h0000_0000, 1'b1, 1'b1, 32'hFFFF_FFFF);
    add_row(OP_READ,  2'd2, 32'h0000_0000, 1'b1, 1'b1, 32'hFFFF_FFFF);
    add_row(OP_READ,  2'd3, 32'h0000_0000, 1'b1, 1'b1, 32'hFFFF_FFFF);
    add_row(OP_WRITE, 2'd0, 32'h1234_5678, 1'b1, 1'b1, '0);
    add_row(OP_WRITE, 2'd0, 32'h0000_0009, 1'b1, 1'b0, '0);
    add_row(OP_READ,  2'd1, 32'hFFFF_FFFF);
    add_row(OP_READ,  2'd2, 32'hFFFF_FFFF);
    add_row(OP_READ,  2'd3, 32'hFFFF_FFFF);
    add_row(OP_WRITE, 2'd3, 32'h0F0F_0F0F);
    add_row(OP_READ,  2'd0, 32'h0000_0000);

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (stim_rows[i])
      issue(stim_rows[i].op, stim_rows[i].rid, stim_rows[i].wdata,
            stim_rows[i].quoted, stim_rows[i].outcome, 1'b1);

    // Vary the write share so the ring swings between empty, full and steady flow
    write_pct = 50;
    for (int n = 0; n < RANDOM_COUNT; n++) begin
      if (n % 50 == 0) begin
        case ($urandom_range(0, 3))
          0:       write_pct = 15;
          1:       write_pct = 40;
          2:       write_pct = 55;
          default: write_pct = 85;
        endcase
      end
      op = ($urandom_range(0, 99) < write_pct) ? OP_WRITE : OP_READ;
      case ($urandom_range(0, 9))
        0:       wdata = '0;
        1:       wdata = '1;
        default: wdata = $urandom;
      endcase
      issue(op, READER_ID_W'($urandom_range(0, 3)), wdata, 1'b0, none,
            n < RANDOM_COUNT - CALM_TAIL);
    end
    start = 1'b0;

    while (awaited_results.size() != 0 || quoted_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches, %0d results never seen", mismatches, awaited_results.size());
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
